[design/chks_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the chained hash key set.
package chks_pkg;

   // Table geometry
   localparam int MAX_BUCKET_BITS = 8;
   localparam int MIN_BUCKET_BITS = 3;
   localparam int CHAIN_DEPTH     = 8;
   localparam int KEY_WIDTH       = 32;
   localparam int NUM_BUCKETS     = 1 << MAX_BUCKET_BITS;
   localparam int SLOT_W          = $clog2(CHAIN_DEPTH);
   localparam int FILL_W          = $clog2(CHAIN_DEPTH + 1);
   localparam int BKT_W           = MAX_BUCKET_BITS;
   localparam int IT_BKT_W        = MAX_BUCKET_BITS + 1;
   localparam int STORE_ADDR_W    = BKT_W + SLOT_W;
   localparam int STORE_DEPTH     = NUM_BUCKETS * CHAIN_DEPTH;

   // Register port
   localparam int CFG_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CFG_W-1:0]     BUCKET_BITS_RESET = CFG_W'(8);
   localparam logic [CSR_IDX_W-1:0] REG_BUCKET_BITS   = CSR_IDX_W'(0);

   // Action codes
   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_INSERT     = ACT_W'(0);
   localparam logic [ACT_W-1:0] ACT_CONTAINS   = ACT_W'(1);
   localparam logic [ACT_W-1:0] ACT_REMOVE     = ACT_W'(2);
   localparam logic [ACT_W-1:0] ACT_ITER_START = ACT_W'(3);
   localparam logic [ACT_W-1:0] ACT_ITER_NEXT  = ACT_W'(4);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_INS_END,
      ST_IT_BKT,
      ST_IT_RD,
      ST_IT_CHK
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take;            // latch the incoming item
      logic scan_clear;      // restart the chain scan
      logic fill_rd;         // read a chain fill count
      logic slot_rd;         // read one slot
      logic use_iter;        // address reads from the iterator
      logic scan_next;       // step the chain scan
      logic remove_wr;       // clear the matching slot
      logic insert_wr;       // place the key in the chain
      logic iter_reset;      // rewind the iterator
      logic iter_adv_bucket; // move the iterator to the next bucket
      logic res_set;         // capture the result
      logic res_hit;
      logic res_full;
      logic res_key;         // return the slot just read
      logic rsp_load;        // move the result to the output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic key_zero;
      logic slot_left;
      logic slot_match;
      logic slot_zero;
      logic ins_refused;
      logic iter_more;
      logic iter_slot_left;
      logic rsp_free;
   } sts_type;

endpackage

[design/chks_ctrl.sv]
// Controller state machine that sequences chain scans and iteration walks.
module chks_ctrl import chks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // Track a captured result not yet moved to the output register
   logic done_pending_ff;
   logic done_pending_in;
   logic done;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Hold a finished item until the output register can take it
            if (done_pending_ff) begin
               if (sts.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  done         = 1'b1;
               end
            end
            req_ready = !done_pending_ff || sts.rsp_free;
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.action)
               ACT_INSERT, ACT_CONTAINS, ACT_REMOVE: begin
                  if (sts.key_zero) begin
                     cmd.res_set = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.fill_rd    = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_SLOT_RD;
                  end
               end
               ACT_ITER_START: begin
                  cmd.iter_reset = 1'b1;
                  cmd.res_set    = 1'b1;
                  state_in       = ST_IDLE;
               end
               ACT_ITER_NEXT: begin
                  state_in = ST_IT_BKT;
               end
               default: begin
                  cmd.res_set = 1'b1;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_SLOT_RD: begin
            if (sts.slot_left) begin
               cmd.slot_rd = 1'b1;
               state_in    = ST_SLOT_CHK;
            end else begin
               state_in = ST_INS_END;
            end
         end
         ST_SLOT_CHK: begin
            if (sts.slot_match) begin
               cmd.remove_wr = (sts.action == ACT_REMOVE);
               cmd.res_set   = 1'b1;
               cmd.res_hit   = (sts.action != ACT_INSERT);
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SLOT_RD;
            end
         end
         ST_INS_END: begin
            // Key absent: insert places it unless the chain is full, others report a miss
            cmd.res_set = 1'b1;
            if (sts.action == ACT_INSERT) begin
               cmd.insert_wr = 1'b1;
               cmd.res_hit   = !sts.ins_refused;
               cmd.res_full  = sts.ins_refused;
            end
            state_in = ST_IDLE;
         end
         ST_IT_BKT: begin
            if (sts.iter_more) begin
               cmd.fill_rd  = 1'b1;
               cmd.use_iter = 1'b1;
               state_in     = ST_IT_RD;
            end else begin
               cmd.res_set = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_IT_RD: begin
            if (sts.iter_slot_left) begin
               cmd.slot_rd  = 1'b1;
               cmd.use_iter = 1'b1;
               state_in     = ST_IT_CHK;
            end else begin
               cmd.iter_adv_bucket = 1'b1;
               state_in            = ST_IT_BKT;
            end
         end
         ST_IT_CHK: begin
            if (!sts.slot_zero) begin
               cmd.res_set = 1'b1;
               cmd.res_hit = 1'b1;
               cmd.res_key = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_IT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      done_pending_in = done_pending_ff;
      if (cmd.res_set) begin
         done_pending_in = 1'b1;
      end else if (done) begin
         done_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_pending_ff <= 1'b0;
      end else begin
         done_pending_ff <= done_pending_in;
      end
   end

endmodule

[design/chks_dp.sv]
// Datapath: slot and fill memories, scan and iterator registers, config register, output stage.
module chks_dp import chks_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [KEY_WIDTH-1:0]  req_key,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [KEY_WIDTH-1:0]  rsp_key_out,
   output logic                  rsp_bucket_full
);

   // Config register
   logic [CFG_W-1:0]     cfg_bits_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && (csr_idx == REG_BUCKET_BITS);
   assign csr_prdata = (csr_idx == REG_BUCKET_BITS) ? CSR_DATA_W'(cfg_bits_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bits_ff <= BUCKET_BITS_RESET;
      end else if (csr_wr) begin
         cfg_bits_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // Clamp the bucket count and derive mask and count
   logic [CFG_W-1:0]    eff_bits;
   logic [IT_BKT_W-1:0] bkt_count;
   logic [BKT_W-1:0]    bkt_mask;

   always_comb begin
      eff_bits = cfg_bits_ff;
      if (cfg_bits_ff < CFG_W'(MIN_BUCKET_BITS)) begin
         eff_bits = CFG_W'(MIN_BUCKET_BITS);
      end else if (cfg_bits_ff > CFG_W'(MAX_BUCKET_BITS)) begin
         eff_bits = CFG_W'(MAX_BUCKET_BITS);
      end
   end

   assign bkt_count = IT_BKT_W'(1) << eff_bits;
   assign bkt_mask  = BKT_W'(bkt_count - IT_BKT_W'(1));

   // Latch the item
   logic [ACT_W-1:0]     act_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [BKT_W-1:0]     bkt_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         act_ff <= req_action;
         key_ff <= req_key;
         bkt_ff <= req_key[2 +: BKT_W] & bkt_mask;
      end
   end

   // Iterator position
   logic [IT_BKT_W-1:0] iter_bkt_ff;
   logic [FILL_W-1:0]   iter_slot_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.iter_reset) begin
         iter_bkt_ff  <= '0;
         iter_slot_ff <= '0;
      end else if (cmd.iter_adv_bucket) begin
         iter_bkt_ff  <= iter_bkt_ff + IT_BKT_W'(1);
         iter_slot_ff <= '0;
      end else if (cmd.slot_rd && cmd.use_iter) begin
         iter_slot_ff <= iter_slot_ff + FILL_W'(1);
      end
   end

   // Chain scan position and first emptied slot
   logic [FILL_W-1:0] idx_ff;
   logic              empty_found_ff;
   logic [SLOT_W-1:0] empty_idx_ff;
   logic [KEY_WIDTH-1:0] slot_q_ff;
   logic              slot_zero;

   assign slot_zero = (slot_q_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         idx_ff         <= '0;
         empty_found_ff <= 1'b0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + FILL_W'(1);
         if (slot_zero && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= idx_ff[SLOT_W-1:0];
         end
      end
   end

   // Fill count memory with per-bucket valid bits
   logic [FILL_W-1:0] fill_mem_ff [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] fill_vld_ff;
   logic [FILL_W-1:0] fill_q_ff;
   logic [BKT_W-1:0]  fill_raddr;
   logic              fill_we;
   logic [FILL_W-1:0] fill_wdata;
   logic              chain_full;

   assign fill_raddr = cmd.use_iter ? iter_bkt_ff[BKT_W-1:0] : bkt_ff;
   assign fill_wdata = fill_q_ff + FILL_W'(1);
   assign chain_full = (fill_q_ff == FILL_W'(CHAIN_DEPTH));

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem_ff[bkt_ff] <= fill_wdata;
      end
      if (cmd.fill_rd) begin
         fill_q_ff <= fill_vld_ff[fill_raddr] ? fill_mem_ff[fill_raddr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (fill_we) begin
         fill_vld_ff[bkt_ff] <= 1'b1;
      end
   end

   // Slot memory write selection
   logic [KEY_WIDTH-1:0]    slot_mem_ff [STORE_DEPTH];
   logic                    store_we;
   logic [STORE_ADDR_W-1:0] store_waddr;
   logic [KEY_WIDTH-1:0]    store_wdata;
   logic [STORE_ADDR_W-1:0] store_raddr;

   always_comb begin
      store_we    = 1'b0;
      store_waddr = {bkt_ff, idx_ff[SLOT_W-1:0]};
      store_wdata = '0;
      fill_we     = 1'b0;
      priority if (cmd.remove_wr) begin
         store_we = 1'b1;
      end else if (cmd.insert_wr) begin
         store_wdata = key_ff;
         priority if (empty_found_ff) begin
            store_we    = 1'b1;
            store_waddr = {bkt_ff, empty_idx_ff};
         end else if (!chain_full) begin
            store_we    = 1'b1;
            store_waddr = {bkt_ff, fill_q_ff[SLOT_W-1:0]};
            fill_we     = 1'b1;
         end else begin
            store_we = 1'b0;
         end
      end else begin
         store_we = 1'b0;
      end
   end

   assign store_raddr = cmd.use_iter ? {iter_bkt_ff[BKT_W-1:0], iter_slot_ff[SLOT_W-1:0]}
                                     : {bkt_ff, idx_ff[SLOT_W-1:0]};

   always_ff @(posedge clock) begin
      if (store_we) begin
         slot_mem_ff[store_waddr] <= store_wdata;
      end
      if (cmd.slot_rd) begin
         slot_q_ff <= slot_mem_ff[store_raddr];
      end
   end

   // Result capture
   logic                 res_hit_ff;
   logic                 res_full_ff;
   logic [KEY_WIDTH-1:0] res_key_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_hit_ff  <= cmd.res_hit;
         res_full_ff <= cmd.res_full;
         res_key_ff  <= cmd.res_key ? slot_q_ff : '0;
      end
   end

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_full_ff;
   logic [KEY_WIDTH-1:0] rsp_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_full_ff <= res_full_ff;
         rsp_key_ff  <= res_key_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_bucket_full = rsp_full_ff;
   assign rsp_key_out     = rsp_key_ff;

   // Status to the controller
   always_comb begin
      sts                = '0;
      sts.action         = act_ff;
      sts.key_zero       = (key_ff == '0);
      sts.slot_left      = (idx_ff < fill_q_ff);
      sts.slot_match     = (slot_q_ff == key_ff);
      sts.slot_zero      = slot_zero;
      sts.ins_refused    = !empty_found_ff && chain_full;
      sts.iter_more      = (iter_bkt_ff < bkt_count);
      sts.iter_slot_left = (iter_slot_ff < fill_q_ff);
      sts.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

endmodule

[design/chained_hash_key_set_unit.sv]
// Top level of the chained hash key set: controller, datapath and register port.
//
//   channel   direction  handshake                     payload
//   req_      in         req_valid / req_ready         req_action, req_key
//   rsp_      out        rsp_valid / rsp_ready         rsp_hit, rsp_key_out, rsp_bucket_full
//   csr_      in         psel/penable/pwrite, pready=1 paddr, pwdata, prdata
//
// Insert, contains and remove read the chain's fill count, then its slots one by one until
// a match or the end of the chain; a zero key and other actions skip the scan.
// Iteration next reads each bucket's fill count and its slots until it finds a nonzero key.
// Reset clears the fill valid bits and the iterator and sets the config register to its reset value; no sweep.
// A finished item waits in the output register while the next item runs; the input is taken
// only when idle, and stalls there only while a second result waits behind one the result channel has not taken.
module chained_hash_key_set_unit import chks_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [KEY_WIDTH-1:0]  req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [KEY_WIDTH-1:0]  rsp_key_out,
   output logic                  rsp_bucket_full,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type cmd;
   sts_type sts;

   // Register port never stalls
   assign csr_pready = 1'b1;

   chks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chks_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_key         (req_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_key_out     (rsp_key_out),
      .rsp_bucket_full (rsp_bucket_full)
   );

endmodule
